// ----- src/spsl_pkg.sv -----
package spsl_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int CMD_W = 3;
    localparam int CHAN_SEL_W = 4;
    localparam int PULSE_W = 12;
    localparam int ANGLE_W = 8;
    localparam int STEP_W = 8;
    localparam int INTERVAL_W = 10;

    localparam int FULL_ANGLE = 180;
    localparam int CENTER_ANGLE = 90;
    localparam int RESET_MIN = 500;
    localparam int RESET_MAX = 2500;
    localparam int RESET_STEP = 5;
    localparam int RESET_INTERVAL = 10;
    localparam int HOME_PULSE = RESET_MIN
        + (CENTER_ANGLE * (RESET_MAX - RESET_MIN)) / FULL_ANGLE;
    localparam int TICK_CAP = 1023;

    localparam int DIV_W = 20;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // x / 180 as ((x >> 2) * RECIP_45) >> 24, RECIP_45 just above 2**24 / 45
    localparam int RECIP_W = 19;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_45 = 372829;
    localparam int RECIP_PROD_W = DIV_W - 2 + RECIP_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_SET     = 3'd1,
        CMD_ESTOP   = 3'd2,
        CMD_STOPALL = 3'd3,
        CMD_QUERY   = 3'd4
    } cmd_code_t;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SET     = 3'd1,
        OP_ESTOP   = 3'd2,
        OP_STOPALL = 3'd3,
        OP_QUERY   = 3'd4,
        OP_REJECT  = 3'd5
    } op_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE       = 2'd0,
        REG_MAX_PULSE       = 2'd1,
        REG_STEP_SIZE       = 2'd2,
        REG_UPDATE_INTERVAL = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [CHAN_SEL_W-1:0] chan_sel;
        logic [ANGLE_W-1:0]    req_angle;
    } item_t;

    typedef struct packed {
        logic [CHAN_SEL_W-1:0] out_chan;
        logic [PULSE_W-1:0]    pulse_now;
        logic [ANGLE_W-1:0]    angle_now;
        logic                  moving;
        logic                  active;
        logic                  rejected;
        logic                  last;
    } result_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [CH_W-1:0]    chan;
        logic [ANGLE_W-1:0] angle;
    } op_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [PULSE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- src/spsl_front.sv -----
module spsl_front (
    input  logic             push,
    input  spsl_pkg::item_t  item,
    output logic             full,
    output logic             op_push,
    output spsl_pkg::op_t    op_data,
    input  logic             op_full
);

    logic                              in_range;
    logic [spsl_pkg::ANGLE_W-1:0]      clamped;
    logic [spsl_pkg::CHAN_SEL_W-1:0]   sel_less;
    logic                              known;
    spsl_pkg::op_kind_t                kind;

    assign full = op_full;
    assign in_range = (item.chan_sel >= spsl_pkg::CHAN_SEL_W'(1))
        && (item.chan_sel <= spsl_pkg::CHAN_SEL_W'(spsl_pkg::NUM_CHANNELS));
    assign clamped = (item.req_angle > spsl_pkg::ANGLE_W'(spsl_pkg::FULL_ANGLE))
        ? spsl_pkg::ANGLE_W'(spsl_pkg::FULL_ANGLE) : item.req_angle;
    assign sel_less = item.chan_sel - spsl_pkg::CHAN_SEL_W'(1);

    always_comb
    begin
        known = 1'b1;
        kind = spsl_pkg::OP_QUERY;
        unique case (item.cmd)
            spsl_pkg::CMD_TICK:
            begin
                kind = spsl_pkg::OP_TICK;
            end
            spsl_pkg::CMD_STOPALL:
            begin
                kind = spsl_pkg::OP_STOPALL;
            end
            spsl_pkg::CMD_SET:
            begin
                kind = in_range ? spsl_pkg::OP_SET : spsl_pkg::OP_REJECT;
            end
            spsl_pkg::CMD_ESTOP:
            begin
                kind = in_range ? spsl_pkg::OP_ESTOP : spsl_pkg::OP_REJECT;
            end
            spsl_pkg::CMD_QUERY:
            begin
                kind = in_range ? spsl_pkg::OP_QUERY : spsl_pkg::OP_REJECT;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // unknown commands are taken and dropped
    assign op_push = push && !op_full && known;
    assign op_data.kind = kind;
    assign op_data.chan = sel_less[spsl_pkg::CH_W-1:0];
    assign op_data.angle = clamped;

endmodule

// ----- src/spsl_op_queue.sv -----
module spsl_op_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  spsl_pkg::op_t  data_in,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output spsl_pkg::op_t  data_out
);

    spsl_pkg::op_t mem_reg [2];
    logic          wptr_reg;
    logic          wptr_next;
    logic          rptr_reg;
    logic          rptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign data_out = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= data_in;
        end
    end

endmodule

// ----- src/spsl_res_queue.sv -----
module spsl_res_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  spsl_pkg::result_t data_in,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output spsl_pkg::result_t data_out
);

    spsl_pkg::result_t mem_reg [2];
    logic              wptr_reg;
    logic              wptr_next;
    logic              rptr_reg;
    logic              rptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_push;
    logic              do_pop;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign data_out = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= data_in;
        end
    end

endmodule

// ----- src/spsl_divider.sv -----
module spsl_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  spsl_pkg::div_req_t req,
    output spsl_pkg::div_rsp_t rsp
);

    logic                            busy_reg;
    logic                            busy_next;
    logic                            done_reg;
    logic                            done_next;
    logic [spsl_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [spsl_pkg::DIV_CNT_W-1:0]  cnt_next;
    logic [spsl_pkg::DIV_W-1:0]      quo_reg;
    logic [spsl_pkg::DIV_W-1:0]      quo_next;
    logic [spsl_pkg::PULSE_W-1:0]    rem_reg;
    logic [spsl_pkg::PULSE_W-1:0]    rem_next;
    logic [spsl_pkg::PULSE_W-1:0]    dsr_reg;
    logic [spsl_pkg::PULSE_W-1:0]    dsr_next;
    logic [spsl_pkg::PULSE_W:0]      shifted;
    logic [spsl_pkg::PULSE_W:0]      diff;
    logic                            fits;

    assign shifted = {rem_reg, quo_reg[spsl_pkg::DIV_W-1]};
    assign diff = shifted - {1'b0, dsr_reg};
    assign fits = (shifted >= {1'b0, dsr_reg});

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next = spsl_pkg::DIV_CNT_W'(spsl_pkg::DIV_W);
            quo_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[spsl_pkg::PULSE_W-1:0] : shifted[spsl_pkg::PULSE_W-1:0];
            quo_next = {quo_reg[spsl_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - spsl_pkg::DIV_CNT_W'(1);
            if (cnt_reg == spsl_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

// ----- src/spsl_back.sv -----
module spsl_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                op_empty,
    input  spsl_pkg::op_t                       op_data,
    output logic                                op_pop,
    output logic                                res_push,
    output spsl_pkg::result_t                   res_data,
    input  logic                                res_full,
    output spsl_pkg::div_req_t                  div_req,
    input  spsl_pkg::div_rsp_t                  div_rsp,
    input  logic                                wr_en,
    input  logic [spsl_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [spsl_pkg::CFG_DATA_W-1:0]     wr_data
);

    localparam int N = spsl_pkg::NUM_CHANNELS;
    localparam int PW = spsl_pkg::PULSE_W;
    localparam int IW = spsl_pkg::INTERVAL_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_SDIV  = 9'b000000100,
        S_SWAIT = 9'b000001000,
        S_APPLY = 9'b000010000,
        S_ANGLE = 9'b000100000,
        S_ADIV  = 9'b001000000,
        S_AWAIT = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    spsl_pkg::op_kind_t                  kind_reg;
    spsl_pkg::op_kind_t                  kind_next;
    logic [spsl_pkg::CH_W-1:0]           ch_reg;
    logic [spsl_pkg::CH_W-1:0]           ch_next;
    logic [spsl_pkg::ANGLE_W-1:0]        ang_in_reg;
    logic [spsl_pkg::ANGLE_W-1:0]        ang_in_next;
    logic [spsl_pkg::ANGLE_W-1:0]        angle_reg;
    logic [spsl_pkg::ANGLE_W-1:0]        angle_next;
    logic [spsl_pkg::DIV_W-1:0]          dividend_reg;
    logic [spsl_pkg::DIV_W-1:0]          dividend_next;
    logic [PW-1:0]                       divisor_reg;
    logic [PW-1:0]                       divisor_next;
    logic [PW-1:0]                       setq_reg;
    logic [PW-1:0]                       setq_next;

    logic [PW-1:0]                       min_reg;
    logic [PW-1:0]                       min_next;
    logic [PW-1:0]                       max_reg;
    logic [PW-1:0]                       max_next;
    logic [spsl_pkg::STEP_W-1:0]         step_reg;
    logic [spsl_pkg::STEP_W-1:0]         step_next;
    logic [IW-1:0]                       intv_reg;
    logic [IW-1:0]                       intv_next;

    logic [PW-1:0]                       cur_reg [N];
    logic [PW-1:0]                       cur_next [N];
    logic [PW-1:0]                       tgt_reg [N];
    logic [PW-1:0]                       tgt_next [N];
    logic                                en_reg [N];
    logic                                en_next [N];
    logic [IW-1:0]                       el_reg [N];
    logic [IW-1:0]                       el_next [N];

    logic [PW-1:0]                       cur_w;
    logic [PW-1:0]                       tgt_w;
    logic [IW-1:0]                       el_inc;
    logic [PW-1:0]                       slew_w;
    logic [PW-1:0]                       up_gap;
    logic [PW-1:0]                       dn_gap;
    logic                                span_up;
    logic [PW-1:0]                       span;
    logic [spsl_pkg::DIV_W-1:0]          mul_set;
    logic [spsl_pkg::DIV_W-1:0]          mul_ang;
    logic [spsl_pkg::RECIP_PROD_W-1:0]   recip_prod;
    logic                                multi;
    logic                                last_ch;
    logic                                rej;

    assign cur_w = cur_reg[ch_reg];
    assign tgt_w = tgt_reg[ch_reg];
    assign el_inc = (el_reg[ch_reg] < IW'(spsl_pkg::TICK_CAP))
        ? el_reg[ch_reg] + IW'(1) : el_reg[ch_reg];
    assign up_gap = tgt_w - cur_w;
    assign dn_gap = cur_w - tgt_w;

    always_comb
    begin
        if (cur_w < tgt_w)
        begin
            slew_w = (up_gap <= PW'(step_reg)) ? tgt_w : cur_w + PW'(step_reg);
        end
        else if (cur_w > tgt_w)
        begin
            slew_w = (dn_gap <= PW'(step_reg)) ? tgt_w : cur_w - PW'(step_reg);
        end
        else
        begin
            slew_w = cur_w;
        end
    end

    assign span_up = (max_reg >= min_reg);
    assign span = span_up ? max_reg - min_reg : min_reg - max_reg;
    assign mul_set = spsl_pkg::DIV_W'(ang_in_reg) * spsl_pkg::DIV_W'(span);
    assign mul_ang = spsl_pkg::DIV_W'(cur_w - min_reg)
        * spsl_pkg::DIV_W'(spsl_pkg::FULL_ANGLE);
    assign recip_prod = spsl_pkg::RECIP_PROD_W'(dividend_reg[spsl_pkg::DIV_W-1:2])
        * spsl_pkg::RECIP_PROD_W'(spsl_pkg::RECIP_45);
    assign multi = (kind_reg == spsl_pkg::OP_TICK) || (kind_reg == spsl_pkg::OP_STOPALL);
    assign last_ch = (ch_reg == spsl_pkg::CH_W'(N - 1));
    assign rej = (kind_reg == spsl_pkg::OP_REJECT);

    always_comb
    begin
        if (rej)
        begin
            res_data = '0;
            res_data.rejected = 1'b1;
            res_data.last = 1'b1;
        end
        else
        begin
            res_data.out_chan = spsl_pkg::CHAN_SEL_W'(ch_reg) + spsl_pkg::CHAN_SEL_W'(1);
            res_data.pulse_now = cur_w;
            res_data.angle_now = angle_reg;
            res_data.moving = (cur_w != tgt_w);
            res_data.active = en_reg[ch_reg];
            res_data.rejected = 1'b0;
            res_data.last = !multi || last_ch;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        ch_next = ch_reg;
        ang_in_next = ang_in_reg;
        angle_next = angle_reg;
        dividend_next = dividend_reg;
        divisor_next = divisor_reg;
        setq_next = setq_reg;
        min_next = min_reg;
        max_next = max_reg;
        step_next = step_reg;
        intv_next = intv_reg;
        cur_next = cur_reg;
        tgt_next = tgt_reg;
        en_next = en_reg;
        el_next = el_reg;
        op_pop = 1'b0;
        res_push = 1'b0;
        div_req.start = 1'b0;
        div_req.dividend = dividend_reg;
        div_req.divisor = divisor_reg;

        if (wr_en)
        begin
            unique case (wr_index)
                spsl_pkg::REG_MIN_PULSE:       min_next = wr_data[PW-1:0];
                spsl_pkg::REG_MAX_PULSE:       max_next = wr_data[PW-1:0];
                spsl_pkg::REG_STEP_SIZE:       step_next = wr_data[spsl_pkg::STEP_W-1:0];
                spsl_pkg::REG_UPDATE_INTERVAL: intv_next = wr_data[IW-1:0];
                default:                       min_next = min_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!op_empty)
                begin
                    op_pop = 1'b1;
                    kind_next = op_data.kind;
                    ang_in_next = op_data.angle;
                    if ((op_data.kind == spsl_pkg::OP_TICK)
                        || (op_data.kind == spsl_pkg::OP_STOPALL))
                    begin
                        ch_next = '0;
                    end
                    else
                    begin
                        ch_next = op_data.chan;
                    end
                    if (op_data.kind == spsl_pkg::OP_REJECT)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (op_data.kind == spsl_pkg::OP_SET)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_MUL:
            begin
                dividend_next = mul_set;
                state_next = S_SDIV;
            end
            S_SDIV:
            begin
                setq_next = recip_prod[spsl_pkg::RECIP_SHIFT +: PW];
                state_next = S_SWAIT;
            end
            S_SWAIT:
            begin
                tgt_next[ch_reg] = span_up ? min_reg + setq_reg : min_reg - setq_reg;
                en_next[ch_reg] = 1'b1;
                el_next[ch_reg] = '0;
                state_next = S_ANGLE;
            end
            S_APPLY:
            begin
                unique case (kind_reg)
                    spsl_pkg::OP_TICK:
                    begin
                        if (en_reg[ch_reg])
                        begin
                            if (el_inc >= intv_reg)
                            begin
                                el_next[ch_reg] = '0;
                                cur_next[ch_reg] = slew_w;
                            end
                            else
                            begin
                                el_next[ch_reg] = el_inc;
                            end
                        end
                    end
                    spsl_pkg::OP_STOPALL, spsl_pkg::OP_ESTOP:
                    begin
                        tgt_next[ch_reg] = cur_w;
                    end
                    default:
                    begin
                        tgt_next[ch_reg] = tgt_w;
                    end
                endcase
                state_next = S_ANGLE;
            end
            S_ANGLE:
            begin
                if ((max_reg <= min_reg) || (cur_w <= min_reg))
                begin
                    angle_next = '0;
                    state_next = S_EMIT;
                end
                else if (cur_w >= max_reg)
                begin
                    angle_next = spsl_pkg::ANGLE_W'(spsl_pkg::FULL_ANGLE);
                    state_next = S_EMIT;
                end
                else
                begin
                    dividend_next = mul_ang;
                    divisor_next = max_reg - min_reg;
                    state_next = S_ADIV;
                end
            end
            S_ADIV:
            begin
                div_req.start = 1'b1;
                state_next = S_AWAIT;
            end
            S_AWAIT:
            begin
                if (div_rsp.done)
                begin
                    angle_next = div_rsp.quotient[spsl_pkg::ANGLE_W-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (multi && !last_ch)
                    begin
                        ch_next = ch_reg + spsl_pkg::CH_W'(1);
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg <= spsl_pkg::OP_TICK;
            ch_reg <= '0;
            min_reg <= PW'(spsl_pkg::RESET_MIN);
            max_reg <= PW'(spsl_pkg::RESET_MAX);
            step_reg <= spsl_pkg::STEP_W'(spsl_pkg::RESET_STEP);
            intv_reg <= IW'(spsl_pkg::RESET_INTERVAL);
            for (int i = 0; i < N; i++)
            begin
                cur_reg[i] <= PW'(spsl_pkg::HOME_PULSE);
                tgt_reg[i] <= PW'(spsl_pkg::HOME_PULSE);
                en_reg[i] <= 1'b0;
                el_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            kind_reg <= kind_next;
            ch_reg <= ch_next;
            min_reg <= min_next;
            max_reg <= max_next;
            step_reg <= step_next;
            intv_reg <= intv_next;
            cur_reg <= cur_next;
            tgt_reg <= tgt_next;
            en_reg <= en_next;
            el_reg <= el_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ang_in_reg <= ang_in_next;
        angle_reg <= angle_next;
        dividend_reg <= dividend_next;
        divisor_reg <= divisor_next;
        setq_reg <= setq_next;
    end

endmodule

// ----- src/servo_pulse_slew_limiter_unit.sv -----
// channel   direction  handshake             payload
// command   in         push / full           item   (cmd, chan_sel, req_angle)
// result    out        pop / empty           result (out_chan .. last)
// config    in         wr_en, no wait        wr_index, wr_data
//
// commands queue two deep in front of a single sequencer; results queue two deep after it
// per channel: S_APPLY, S_ANGLE, S_EMIT; S_ADIV, S_AWAIT too when the angle is divided
// a command is taken in S_IDLE; set angle finds its target in S_MUL..S_SWAIT, not S_APPLY
// reset clears the queues, loads register defaults and centers every channel
// a full result queue stalls the sequencer while commands keep queuing until full

module servo_pulse_slew_limiter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  spsl_pkg::item_t                     item,
    output logic                                full,
    output logic                                empty,
    input  logic                                pop,
    output spsl_pkg::result_t                   result,
    input  logic                                wr_en,
    input  logic [spsl_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [spsl_pkg::CFG_DATA_W-1:0]     wr_data
);

    logic               op_push;
    logic               op_full;
    logic               op_empty;
    logic               op_pop;
    spsl_pkg::op_t      op_in;
    spsl_pkg::op_t      op_out;
    logic               res_push;
    logic               res_full;
    spsl_pkg::result_t  res_in;
    spsl_pkg::div_req_t div_req;
    spsl_pkg::div_rsp_t div_rsp;

    spsl_front u_front (
        .push    (push),
        .item    (item),
        .full    (full),
        .op_push (op_push),
        .op_data (op_in),
        .op_full (op_full)
    );

    spsl_op_queue u_op_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (op_push),
        .data_in  (op_in),
        .full     (op_full),
        .pop      (op_pop),
        .empty    (op_empty),
        .data_out (op_out)
    );

    spsl_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    spsl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (op_empty),
        .op_data  (op_out),
        .op_pop   (op_pop),
        .res_push (res_push),
        .res_data (res_in),
        .res_full (res_full),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    spsl_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  (res_in),
        .full     (res_full),
        .pop      (pop),
        .empty    (empty),
        .data_out (result)
    );

    a_op_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(op_push && op_full))
        else $error("command queue written while full");

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && res_full))
        else $error("result queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(op_pop && op_empty))
        else $error("sequencer took a command from an empty queue");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_in.angle_now <= spsl_pkg::ANGLE_W'(spsl_pkg::FULL_ANGLE)))
        else $error("reported angle above full angle");

endmodule
